FILE: hw/rtl/pidfd_pkg.sv
// pidfd_pkg: shared types, constants and helpers for the filtered-derivative pid block
// used by the top level, controller, datapath and divider rtl files; no dependencies

package pidfd_pkg;

  localparam int ACC_W = 24;
  localparam int SUM_W = 27;
  localparam int DVS_W = 36;

  localparam int HEAT_MAX = 255;
  localparam int HEAT_MIN = 0;
  localparam int COOL_MAX = 0;
  localparam int COOL_MIN = -255;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEGRAL_GAIN = 3'd1,
    REG_DERIV_TIME    = 3'd2,
    REG_FILTER_RATIO  = 3'd3,
    REG_DRIVE_BIAS    = 3'd4,
    REG_SAMPLE_PERIOD = 3'd5
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_P1, OP_P2, OP_KIKP, OP_KIKPH, OP_DIV_KH, OP_I1, OP_I2, OP_KD1000,
    OP_DIV_G, OP_DEN, OP_AMUL, OP_DIV_A, OP_KPKD, OP_KPKDDY, OP_X1000,
    OP_DIV_B, OP_FINAL
  } op_t;

  typedef struct packed {
    op_t  op;
    logic go;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [15:0]        prop_gain;
    logic [15:0]        integral_gain;
    logic [15:0]        deriv_time;
    logic [7:0]         filter_ratio;
    logic signed [8:0]  drive_bias;
    logic [15:0]        sample_period_ms;
  } cfg_t;

  function automatic logic is_div(input op_t op);
    return (op == OP_DIV_KH) || (op == OP_DIV_G) || (op == OP_DIV_A) || (op == OP_DIV_B);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd8388607;
    lo = -64'sd8388608;
    if (x > hi) return hi[ACC_W-1:0];
    if (x < lo) return lo[ACC_W-1:0];
    return x[ACC_W-1:0];
  endfunction

  // arithmetic shift right rounding toward zero
  function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] x,
                                                   input int unsigned k);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

endpackage

FILE: hw/rtl/pidfd_if.sv
// pidfd_if: valid/ready channel interfaces for samples and drive results
// no dependencies

interface pidfd_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] setpoint;
  logic signed [15:0] measured;
  logic               cool_mode;
  modport source(output valid, setpoint, measured, cool_mode, input ready);
  modport sink(input valid, setpoint, measured, cool_mode, output ready);
endinterface

interface pidfd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] drive;
  modport source(output valid, drive, input ready);
  modport sink(input valid, drive, output ready);
endinterface

FILE: hw/rtl/pid_filtered_derivative_antiwindup_unit.sv
// pid_filtered_derivative_antiwindup_unit: top level, configuration registers and glue
// depends on pidfd_pkg, pidfd_if, pidfd_ctrl and pidfd_dp
//
// Samples (setpoint, measured, cool_mode) arrive on the sample channel and one
// drive beat per sample leaves on the result channel, both valid/ready.
// Registers must be written by the user through cfg_we / cfg_index / cfg_data
// only while idle; the block itself does not enforce it. From acceptance to
// its result a sample runs thirteen non-divide steps, the multiplies among
// them on the shared multiplier, three passes through the 64-step radix-2
// divider and a digit-wise divide by 1000. One sample is worked on at a time,
// and the next is accepted once the previous result has been placed in the
// output register, so one result may wait there while a new sample is
// computed. If the receiver stalls, the finished sample holds in its last
// step until the output register frees. Reset clears the controller, the
// stored integral, derivative and last samples, and loads register defaults.

module pid_filtered_derivative_antiwindup_unit import pidfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  pidfd_sample_if.sink          sample,
  pidfd_result_if.source        result,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t st;
  logic  in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain        <= 16'd256;
      cfg.integral_gain    <= 16'd0;
      cfg.deriv_time       <= 16'd0;
      cfg.filter_ratio     <= 8'd1;
      cfg.drive_bias       <= 9'sd0;
      cfg.sample_period_ms <= 16'd100;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PROP_GAIN:     cfg.prop_gain        <= cfg_data;
        REG_INTEGRAL_GAIN: cfg.integral_gain    <= cfg_data;
        REG_DERIV_TIME:    cfg.deriv_time       <= cfg_data;
        REG_FILTER_RATIO:  cfg.filter_ratio     <= cfg_data[7:0];
        REG_DRIVE_BIAS:    cfg.drive_bias       <= cfg_data[8:0];
        REG_SAMPLE_PERIOD: cfg.sample_period_ms <= cfg_data;
        default:           ;
      endcase
    end
  end

  assign sample.ready = in_ready;

  pidfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st)
  );

  pidfd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_fire   (sample.valid && in_ready),
    .setpoint  (sample.setpoint),
    .measured  (sample.measured),
    .cool_mode (sample.cool_mode),
    .cmd       (cmd),
    .st        (st),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .drive     (result.drive)
  );

endmodule

FILE: hw/rtl/pidfd_div.sv
// pidfd_div: radix-2 restoring divider, signed dividend, unsigned divisor, truncating
// depends on pidfd_pkg

module pidfd_div import pidfd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [63:0]      dividend,
  input  logic [DVS_W-1:0]        divisor,
  output logic                    done,
  output logic signed [63:0]      quotient
);

  logic             busy;
  logic [5:0]       cnt;
  logic             neg;
  logic [63:0]      quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;
  logic             ge;

  assign shifted  = {rem, quo[63]};
  assign diff     = {1'b0, shifted} - {2'b0, dvs};
  assign ge       = !diff[DVS_W+1];
  assign quotient = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= dividend[63];
        quo  <= dividend[63] ? -dividend : dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        quo <= {quo[62:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/pidfd_dp.sv
// pidfd_dp: datapath with shared multiplier, divider, state and drive register
// depends on pidfd_pkg and pidfd_div

module pidfd_dp import pidfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_fire,
  input  logic signed [15:0] setpoint,
  input  logic signed [15:0] measured,
  input  logic               cool_mode,
  input  cmd_t               cmd,
  output stat_t              st,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         drive
);

  localparam logic signed [SUM_W-1:0] HEAT_HI8 = SUM_W'(HEAT_MAX * 256);
  localparam logic signed [SUM_W-1:0] HEAT_LO8 = SUM_W'(HEAT_MIN * 256);
  localparam logic signed [SUM_W-1:0] COOL_HI8 = SUM_W'(COOL_MAX * 256);
  localparam logic signed [SUM_W-1:0] COOL_LO8 = SUM_W'(COOL_MIN * 256);

  // ceil(2^36 / 1000), exact quotient for dividends below 2^26
  localparam logic [26:0] KH_RECIP = 27'd68719477;

  logic signed [15:0]      sp_r, y_r, last_m, last_sp;
  logic                    cool_r;
  logic signed [16:0]      e_r, dy_r, le_r;
  logic signed [ACC_W-1:0] integ, dacc, pk, ik, dk;
  logic signed [63:0]      t1;
  logic signed [39:0]      kh;
  logic [26:0]             g;
  logic [27:0]             den;
  logic signed [24:0]      a_q;
  logic signed [47:0]      b_q;
  logic [7:0]              n_eff;
  logic [15:0]             ms_eff;
  logic signed [49:0]      mul_a;
  logic signed [24:0]      mul_b;
  logic signed [74:0]      prod;
  logic                    div_start;
  logic [DVS_W-1:0]        div_dvs;
  logic signed [63:0]      div_q;
  logic                    div_done;
  logic                    fin;
  logic signed [SUM_W-1:0] hi8, lo8, sum, sum_c, integ_n, sum_n;
  logic signed [63:0]      d_full;
  logic [7:0]              drive_n;
  logic                    kstart;
  logic                    kbusy;
  logic                    kdone;
  logic [2:0]              kcnt;
  logic [47:0]             kx;
  logic [9:0]              krem;
  logic [15:0]             kq;
  logic [47:0]             kquo;
  logic [25:0]             kv;
  logic [51:0]             kprod;
  logic [25:0]             kqx;

  assign n_eff  = (cfg.filter_ratio == 8'd0) ? 8'd1 : cfg.filter_ratio;
  assign ms_eff = (cfg.sample_period_ms == 16'd0) ? 16'd1 : cfg.sample_period_ms;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_P1:      begin mul_a = {{33{e_r[16]}}, e_r}; mul_b = {9'b0, cfg.prop_gain}; end
      OP_KIKP:    begin mul_a = {34'b0, cfg.integral_gain}; mul_b = {9'b0, cfg.prop_gain}; end
      OP_KIKPH:   begin mul_a = t1[49:0]; mul_b = {9'b0, ms_eff}; end
      OP_I1:      begin mul_a = {{10{kh[39]}}, kh}; mul_b = {{8{le_r[16]}}, le_r}; end
      OP_KD1000:  begin mul_a = {34'b0, cfg.deriv_time}; mul_b = {15'b0, MS_PER_S}; end
      OP_AMUL:    begin mul_a = {23'b0, g}; mul_b = {dacc[ACC_W-1], dacc}; end
      OP_KPKD:    begin mul_a = {34'b0, cfg.prop_gain}; mul_b = {9'b0, cfg.deriv_time}; end
      OP_KPKDDY:  begin mul_a = t1[49:0]; mul_b = {{8{dy_r[16]}}, dy_r}; end
      OP_X1000:   begin mul_a = t1[49:0]; mul_b = {15'b0, MS_PER_S}; end
      default:    ;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    unique case (cmd.op)
      OP_DIV_G:  div_dvs = {28'b0, n_eff};
      OP_DIV_A:  div_dvs = {8'b0, den};
      default:   div_dvs = {den, 8'b0};
    endcase
  end

  assign div_start = cmd.go && is_div(cmd.op) && (cmd.op != OP_DIV_KH);

  pidfd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (t1),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // divide by 1000 in three 16-bit digits, each a quotient step then a remainder step
  assign kstart = cmd.go && (cmd.op == OP_DIV_KH);
  assign kv     = {krem, kx[47:32]};
  assign kprod  = {26'b0, kv} * {25'b0, KH_RECIP};
  assign kqx    = {10'b0, kq} * {16'b0, MS_PER_S};

  always_ff @(posedge clk) begin
    if (rst) begin
      kbusy <= 1'b0;
      kdone <= 1'b0;
      kcnt  <= '0;
    end else begin
      kdone <= 1'b0;
      if (kstart) begin
        kbusy <= 1'b1;
        kcnt  <= '0;
        kx    <= t1[47:0];
        krem  <= '0;
      end else if (kbusy) begin
        kcnt <= kcnt + 3'd1;
        if (!kcnt[0]) begin
          kq <= kprod[51:36];
        end else begin
          krem <= 10'(kv - kqx);
          kquo <= {kquo[31:0], kq};
          kx   <= {kx[31:0], 16'b0};
        end
        if (kcnt == 3'd5) begin
          kbusy <= 1'b0;
          kdone <= 1'b1;
        end
      end
    end
  end

  assign st.div_done = div_done || kdone;
  assign st.out_free = !out_valid || out_ready;
  assign fin         = cmd.go && (cmd.op == OP_FINAL) && st.out_free;

  // sum, clamp, integral pinning and drive saturation
  always_comb begin
    dk   = sat_acc(64'(a_q) - 64'(b_q));
    hi8  = cool_r ? COOL_HI8 : HEAT_HI8;
    lo8  = cool_r ? COOL_LO8 : HEAT_LO8;
    sum  = SUM_W'(ik) + SUM_W'(dk) + SUM_W'(pk)
         + {{10{cfg.drive_bias[8]}}, cfg.drive_bias, 8'b0};
    if (sum > hi8)
      sum_c = hi8;
    else if (sum <= lo8)
      sum_c = lo8;
    else
      sum_c = sum;
    if (sum_c <= lo8 && SUM_W'(ik) <= lo8)
      integ_n = lo8;
    else if (sum_c >= hi8 && SUM_W'(ik) > hi8)
      integ_n = hi8;
    else
      integ_n = SUM_W'(ik);
    sum_n  = cool_r ? -sum_c : sum_c;
    d_full = shr_trunc(64'(sum_n), 8);
    if (d_full < 64'sd0)
      drive_n = 8'd0;
    else if (d_full > 64'sd255)
      drive_n = 8'd255;
    else
      drive_n = d_full[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_m    <= '0;
      last_sp   <= '0;
      integ     <= '0;
      dacc      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        sp_r   <= setpoint;
        y_r    <= measured;
        cool_r <= cool_mode;
        e_r    <= {setpoint[15], setpoint} - {measured[15], measured};
        dy_r   <= {measured[15], measured} - {last_m[15], last_m};
        le_r   <= {last_sp[15], last_sp} - {last_m[15], last_m};
      end
      if (out_valid && out_ready)
        out_valid <= 1'b0;
      if (cmd.go) begin
        unique case (cmd.op)
          OP_P1, OP_KIKP, OP_KIKPH, OP_I1, OP_KD1000, OP_AMUL, OP_KPKD, OP_KPKDDY,
          OP_X1000: t1 <= prod[63:0];
          OP_P2:    pk <= sat_acc(shr_trunc(t1, 8));
          OP_I2:    ik <= sat_acc(64'(integ) + shr_trunc(t1, 16));
          OP_DEN:   den <= {1'b0, g} + {4'b0, ms_eff, 8'b0};
          default:  ;
        endcase
      end
      if (fin) begin
        last_m    <= y_r;
        last_sp   <= sp_r;
        dacc      <= dk;
        integ     <= integ_n[ACC_W-1:0];
        drive     <= drive_n;
        out_valid <= 1'b1;
      end
      if (kdone)
        kh <= kquo[39:0];
      if (div_done) begin
        unique case (cmd.op)
          OP_DIV_G:  g   <= div_q[26:0];
          OP_DIV_A:  a_q <= div_q[24:0];
          OP_DIV_B:  b_q <= div_q[47:0];
          default:   ;
        endcase
      end
    end
  end

  a_done_in_div_op: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (cmd.op == OP_DIV_KH || cmd.op == OP_DIV_G ||
                  cmd.op == OP_DIV_A || cmd.op == OP_DIV_B))
    else $error("divider finished outside a divide step");

  a_rose_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.go && cmd.op == OP_FINAL))
    else $error("result raised without the final step");

  a_final_posts: assert property (@(posedge clk) disable iff (rst)
    fin |=> out_valid && drive == $past(drive_n))
    else $error("final step did not post its drive");

endmodule

FILE: hw/rtl/pidfd_ctrl.sv
// pidfd_ctrl: sequencer stepping the datapath through one sample's operations
// depends on pidfd_pkg

module pidfd_ctrl import pidfd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output cmd_t  cmd,
  input  stat_t st
);

  typedef enum logic [1:0] {ST_IDLE, ST_STEP, ST_DIV} state_t;

  state_t state;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cmd.op <= OP_P1;
      cmd.go <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state  <= ST_STEP;
            cmd.op <= OP_P1;
            cmd.go <= 1'b1;
          end
        end
        ST_STEP: begin
          priority if (is_div(cmd.op)) begin
            state  <= ST_DIV;
            cmd.go <= 1'b0;
          end else if (cmd.op == OP_FINAL) begin
            if (st.out_free) begin
              state  <= ST_IDLE;
              cmd.go <= 1'b0;
            end
          end else begin
            cmd.op <= op_t'(cmd.op + 5'd1);
          end
        end
        ST_DIV: begin
          if (st.div_done) begin
            state  <= ST_STEP;
            cmd.op <= op_t'(cmd.op + 5'd1);
            cmd.go <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/pidfd_checker.sv
// pidfd_checker: watches the sample, result and register write ports of the pid block,
// predicts each drive value and compares it with the one the block returns
// depends on pidfd_pkg and pidfd_if

module pidfd_checker import pidfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pidfd_sample_if     smp,
  pidfd_result_if     res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t       regs;
  longint     prev_meas;
  longint     prev_sp;
  longint     integ;
  longint     deriv;
  logic [7:0] drive_q[$];

  function automatic longint clamp_q16_8(input longint x);
    if (x > 64'sd8388607) return 64'sd8388607;
    if (x < -64'sd8388608) return -64'sd8388608;
    return x;
  endfunction

  function automatic logic [7:0] next_drive(input logic signed [15:0] sp_in,
                                            input logic signed [15:0] y_in,
                                            input logic cool);
    longint sp, y, kp, ki, kd, n, ms, hi8, lo8;
    longint pk, ik, dk, kh, g, den, a, b, sum, d;
    sp  = sp_in;
    y   = y_in;
    kp  = regs.prop_gain;
    ki  = regs.integral_gain;
    kd  = regs.deriv_time;
    n   = (regs.filter_ratio == 0) ? 1 : regs.filter_ratio;
    ms  = (regs.sample_period_ms == 0) ? 1 : regs.sample_period_ms;
    hi8 = (cool ? COOL_MAX : HEAT_MAX) * 256;
    lo8 = (cool ? COOL_MIN : HEAT_MIN) * 256;

    pk  = clamp_q16_8(kp * (sp - y) / 256);
    kh  = ki * kp * ms / 1000;
    ik  = clamp_q16_8(integ + kh * (prev_sp - prev_meas) / 65536);
    g   = kd * 1000 / n;
    den = g + ms * 256;
    a   = deriv * g / den;
    b   = kp * kd * (y - prev_meas) * 1000 / (den * 256);
    dk  = clamp_q16_8(a - b);
    sum = ik + dk + pk + longint'(regs.drive_bias) * 256;

    prev_meas = y;
    prev_sp   = sp;
    deriv     = dk;

    if (sum > hi8) sum = hi8;
    else if (sum <= lo8) sum = lo8;

    if (sum <= lo8 && ik <= lo8) integ = lo8;
    else if (sum >= hi8 && ik > hi8) integ = hi8;
    else integ = ik;

    if (cool) sum = -sum;
    d = sum / 256;
    if (d < 0) d = 0;
    if (d > 255) d = 255;
    return d[7:0];
  endfunction

  assign pending = drive_q.size();

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      regs.prop_gain        <= 16'd256;
      regs.integral_gain    <= 16'd0;
      regs.deriv_time       <= 16'd0;
      regs.filter_ratio     <= 8'd1;
      regs.drive_bias       <= 9'sd0;
      regs.sample_period_ms <= 16'd100;
      errors    <= 0;
      prev_meas = 0;
      prev_sp   = 0;
      integ     = 0;
      deriv     = 0;
      drive_q.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_PROP_GAIN:     regs.prop_gain        <= cfg_data;
          REG_INTEGRAL_GAIN: regs.integral_gain    <= cfg_data;
          REG_DERIV_TIME:    regs.deriv_time       <= cfg_data;
          REG_FILTER_RATIO:  regs.filter_ratio     <= cfg_data[7:0];
          REG_DRIVE_BIAS:    regs.drive_bias       <= cfg_data[8:0];
          REG_SAMPLE_PERIOD: regs.sample_period_ms <= cfg_data;
          default: ;
        endcase
      end
      if (smp.valid && smp.ready)
        drive_q.push_back(next_drive(smp.setpoint, smp.measured, smp.cool_mode));
      if (res.valid && res.ready) begin
        if (drive_q.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected drive beat, actual %0d", $time, res.drive);
        end else begin
          want = drive_q.pop_front();
          if (want !== res.drive) begin
            errors <= errors + 1;
            $display("%0t: drive mismatch, expected %0d actual %0d", $time, want, res.drive);
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb.sv
// tb: top of the pid block testbench; drives samples, register writes and result stalls
// depends on pidfd_pkg, pidfd_if, the block and pidfd_checker

module tb import pidfd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          errors;
  int          pending;
  int          burst_left;
  int          stall_pct;
  int          stall_cnt;

  pidfd_sample_if smp();
  pidfd_result_if res();

  pid_filtered_derivative_antiwindup_unit u_dut (
    .clk(clk), .rst(rst), .sample(smp), .result(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pidfd_checker u_chk (
    .clk(clk), .rst(rst), .smp(smp), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls: stall rate is redrawn for each stretch of the run, zero in some stretches
  always @(posedge clk) begin
    if (rst) begin
      stall_cnt <= 0;
      stall_pct <= 0;
      res.ready <= 1'b0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 256 == 0)
        case ($urandom_range(0, 3))
          0, 1: stall_pct <= 0;
          2: stall_pct <= 30;
          default: stall_pct <= 80;
        endcase
      res.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic load_regs(input logic [15:0] kp, input logic [15:0] ki,
                           input logic [15:0] kd, input logic [7:0] n,
                           input int bias, input logic [15:0] ms);
    logic [15:0] b16;
    b16 = 16'(bias);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEGRAL_GAIN, ki);
    write_reg(REG_DERIV_TIME, kd);
    write_reg(REG_FILTER_RATIO, {8'd0, n});
    write_reg(REG_DRIVE_BIAS, b16);
    write_reg(REG_SAMPLE_PERIOD, ms);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_sample(input logic signed [15:0] sp, input logic signed [15:0] y,
                             input logic cool);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        smp.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    smp.valid     <= 1'b1;
    smp.setpoint  <= sp;
    smp.measured  <= y;
    smp.cool_mode <= cool;
    do @(negedge clk); while (!smp.ready);
    @(posedge clk);
  endtask

  task automatic random_samples(input int count);
    logic signed [15:0] sp;
    logic signed [15:0] y;
    logic cool;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        sp = 16'($urandom());
        y  = 16'($urandom());
      end else begin
        sp = 16'($urandom_range(0, 20000) - 5000);
        y  = 16'(sp + $urandom_range(0, 2000) - 1000);
      end
      cool = 1'($urandom_range(0, 1));
      send_sample(sp, y, cool);
    end
  endtask

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    smp.valid  = 1'b0;
    smp.setpoint  = '0;
    smp.measured  = '0;
    smp.cool_mode = 1'b0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes in both modes, then a step with a drifting measurement
    load_regs(16'd512, 16'd256, 16'd512, 8'd4, 10, 16'd100);
    for (int c = 0; c < 2; c++) begin
      send_sample(16'sh7fff, -16'sh8000, 1'(c));
      send_sample(-16'sh8000, 16'sh7fff, 1'(c));
      send_sample(16'sh0000, 16'sh0000, 1'(c));
      send_sample(16'sh7fff, 16'sh7fff, 1'(c));
      send_sample(-16'sh8000, -16'sh8000, 1'(c));
      send_sample(16'sd5120, 16'sd4608, 1'(c));
      send_sample(16'sd5120, 16'sd5000, 1'(c));
      send_sample(16'sd5120, 16'sd5200, 1'(c));
      send_sample(16'sd5120, 16'sd5100, 1'(c));
      send_sample(-16'sd1, 16'sd0, 1'(c));
    end
    smp.valid <= 1'b0;
    wait_idle();

    // extremes of every register but the drive bias, which goes to 255 and -255; filter ratio and period zero
    load_regs(16'hffff, 16'hffff, 16'hffff, 8'd255, 255, 16'hffff);
    random_samples(100);
    smp.valid <= 1'b0;
    wait_idle();
    load_regs(16'd0, 16'd0, 16'd0, 8'd0, -255, 16'd0);
    random_samples(100);
    smp.valid <= 1'b0;
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      load_regs(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 1024)),
                16'($urandom_range(0, 4096)), 8'($urandom_range(0, 255)),
                int'($urandom_range(0, 510)) - 255,
                16'($urandom_range(1, 2000)));
      random_samples(330);
      smp.valid <= 1'b0;
      wait_idle();
    end

    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #30000000;
    $display("Verification failed");
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/pidfd_pkg.sv
hw/rtl/pidfd_if.sv
hw/rtl/pidfd_div.sv
hw/rtl/pidfd_dp.sv
hw/rtl/pidfd_ctrl.sv
hw/rtl/pid_filtered_derivative_antiwindup_unit.sv
tb/pidfd_checker.sv
tb/tb.sv
